// ===== src/priority_ready_queue_defines.svh =====
// ----------------------------------------------------------------------------
// priority_ready_queue assertion macros
// shared property shapes for the checker
// ----------------------------------------------------------------------------
`ifndef PRIORITY_READY_QUEUE_DEFINES_SVH
`define PRIORITY_READY_QUEUE_DEFINES_SVH

// same-cycle implication
`define PRQ_ASSERT_IMP(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("priority_ready_queue assertion failed");

// next-cycle implication
`define PRQ_ASSERT_NXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("priority_ready_queue assertion failed");

`endif

// ===== src/prq_pkg.sv =====
// ----------------------------------------------------------------------------
// prq_pkg
// types and codes shared by the ready queue modules
// ----------------------------------------------------------------------------
package prq_pkg;

  localparam int PADDR_W = 3;

  localparam logic       REQ_INSERT = 1'b0;
  localparam logic       REQ_POP    = 1'b1;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  localparam logic [1:0] MODE_FCFS = 2'd0;
  localparam logic [1:0] MODE_SJF  = 2'd1;
  localparam logic [1:0] MODE_PRIO = 2'd2;

  // register select is address bit 2
  localparam logic REG_KEY_MODE     = 1'b0;
  localparam logic REG_DEFAULT_PRIO = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  task_id;
    logic [15:0] burst_estimate;
    logic [15:0] job_priority;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  popped_id;
    logic [15:0] popped_key;
    logic [4:0]  occupancy;
  } out_word_t;

  typedef struct packed {
    logic [15:0] key;
    logic [7:0]  id;
  } entry_t;

  typedef struct packed {
    logic [1:0]  key_mode;
    logic [15:0] fcfs_key;
  } cfg_t;

endpackage

// ===== src/prq_cfg.sv =====
// ----------------------------------------------------------------------------
// prq_cfg
// configuration registers behind the register port
// ----------------------------------------------------------------------------
module prq_cfg
  import prq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  cfg_t cfg_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_KEY_MODE:     cfg_r.key_mode <= pwdata[1:0];
        REG_DEFAULT_PRIO: cfg_r.fcfs_key <= pwdata[15:0];
        default:          cfg_r          <= cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_KEY_MODE:     prdata = {30'd0, cfg_r.key_mode};
      REG_DEFAULT_PRIO: prdata = {16'd0, cfg_r.fcfs_key};
      default:          prdata = '0;
    endcase
  end

endmodule

// ===== src/prq_ram.sv =====
// ----------------------------------------------------------------------------
// prq_ram
// entry store, one write and one registered read port
// ----------------------------------------------------------------------------
module prq_ram
  import prq_pkg::*;
#(
  parameter  int QUEUE_DEPTH = 16,
  localparam int AW          = $clog2(QUEUE_DEPTH)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data
);

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/prq_seq.sv =====
// ----------------------------------------------------------------------------
// prq_seq
// request sequencer: ring of entries, insert walks back from the tail
// ----------------------------------------------------------------------------
module prq_seq
  import prq_pkg::*;
#(
  parameter  int QUEUE_DEPTH = 16,
  localparam int AW          = $clog2(QUEUE_DEPTH),
  localparam int CW          = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  in_word_t      in_word,
  output logic          out_valid,
  output out_word_t     out_word,
  input  cfg_t          cfg,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  input  entry_t        rd_data,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output entry_t        wr_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_POP_RD,
    S_WALK,
    S_PLACE
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  in_word_t      req_r;
  logic          out_valid_r, out_valid_nxt;
  out_word_t     out_word_r, out_word_nxt;
  logic [15:0]   key;
  logic [CW-1:0] count_m1;
  logic [CW+4:0] occ_ext;
  entry_t        new_entry;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [AW-1:0] lidx);
    logic [AW:0] s;
    s = {1'b0, head} + {1'b0, lidx};
    if (s >= (AW+1)'(QUEUE_DEPTH)) begin
      s = s - (AW+1)'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  always_comb begin
    case (cfg.key_mode)
      MODE_SJF:  key = req_r.burst_estimate;
      MODE_PRIO: key = req_r.job_priority;
      default:   key = cfg.fcfs_key;
    endcase
  end

  assign new_entry = '{key: key, id: req_r.task_id};
  assign count_m1  = count_r - 1'b1;
  assign occ_ext   = {5'd0, count_nxt};
  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    head_nxt      = head_r;
    idx_nxt       = idx_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = '0;
    rd_en         = 1'b0;
    rd_addr       = head_r;
    wr_en         = 1'b0;
    wr_addr       = head_r;
    wr_data       = new_entry;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (req_r.req_type == REQ_POP) begin
          if (count_r == '0) begin
            out_valid_nxt       = 1'b1;
            out_word_nxt.status = STATUS_EMPTY;
            state_nxt           = S_IDLE;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = head_r;
            state_nxt = S_POP_RD;
          end
        end else begin
          if (count_r == CW'(QUEUE_DEPTH)) begin
            out_valid_nxt       = 1'b1;
            out_word_nxt.status = STATUS_FULL;
            state_nxt           = S_IDLE;
          end else if (count_r == '0) begin
            wr_en         = 1'b1;
            wr_addr       = head_r;
            count_nxt     = count_r + 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = phys(head_r, count_m1[AW-1:0]);
            idx_nxt   = count_m1[AW-1:0];
            state_nxt = S_WALK;
          end
        end
      end
      S_POP_RD: begin
        head_nxt                = phys(head_r, AW'(1));
        count_nxt               = count_r - 1'b1;
        out_valid_nxt           = 1'b1;
        out_word_nxt.popped_id  = rd_data.id;
        out_word_nxt.popped_key = rd_data.key;
        state_nxt               = S_IDLE;
      end
      S_WALK: begin
        wr_en   = 1'b1;
        wr_addr = phys(head_r, idx_r + 1'b1);
        if (rd_data.key > key) begin
          // shift this entry up one slot
          wr_data = rd_data;
          if (idx_r == '0) begin
            state_nxt = S_PLACE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = phys(head_r, idx_r - 1'b1);
            idx_nxt = idx_r - 1'b1;
          end
        end else begin
          count_nxt     = count_r + 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_PLACE: begin
        wr_en         = 1'b1;
        wr_addr       = head_r;
        count_nxt     = count_r + 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_word_nxt.occupancy = occ_ext[4:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      out_word_r  <= out_word_nxt;
      if (state_r == S_IDLE && start) begin
        req_r <= in_word;
      end
    end
  end

endmodule

// ===== src/priority_ready_queue.sv =====
// ----------------------------------------------------------------------------
// priority_ready_queue
// sorted ready queue of task identifiers, smallest key at the head
// ----------------------------------------------------------------------------
// channel   ports                              handshake
// input     start, busy, in_word               taken when start and not busy
// result    out_valid, out_word                one-cycle strobe, no back-pressure
// config    psel, penable, pwrite, paddr,      write in access phase, pready tied high
//           pwdata, prdata, pready
//
// refusals end in S_CHECK, pops in S_POP_RD, inserts in S_CHECK, S_WALK or S_PLACE
// the insert walk reads and shifts one entry per cycle through the entry ram
// a new word can be taken at the edge that ends the result strobe
// synchronous active-low reset empties the queue, no clearing pass
// ----------------------------------------------------------------------------
module priority_ready_queue
  import prq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  in_word_t           in_word,
  output logic               out_valid,
  output out_word_t          out_word,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  cfg_t          cfg;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  entry_t        rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;

  prq_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  prq_ram #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  prq_seq #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg       (cfg),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

endmodule

// ===== src/prq_checker.sv =====
// ----------------------------------------------------------------------------
// prq_checker
// port-level checks on request and result timing and on refused result contents
// ----------------------------------------------------------------------------
`include "priority_ready_queue_defines.svh"

module prq_checker
  import prq_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input out_word_t out_word,
  input logic      out_valid
);

  // every accepted word sets busy in the cycle after it is taken
  `PRQ_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)

  // a result is a single strobe
  `PRQ_ASSERT_NXT(a_single_strobe, clk, rst_n, out_valid, !out_valid)

  // the result comes out as the block goes idle
  `PRQ_ASSERT_IMP(a_result_idle, clk, rst_n, out_valid, !busy)

  // refused requests carry no popped entry
  `PRQ_ASSERT_IMP(a_refused_zero, clk, rst_n,
    out_valid && (out_word.status != STATUS_DONE),
    (out_word.popped_id == 8'd0) && (out_word.popped_key == 16'd0))

endmodule

bind priority_ready_queue prq_checker u_prq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_word  (out_word),
  .out_valid (out_valid)
);

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// checks the ready queue against a sorted-list model: inserts in every key
// mode, pops, full and empty refusals, register writes and read-back, with
// random start gaps and a final stretch with no gaps
// ----------------------------------------------------------------------------
module tb_top
  import prq_pkg::*;
();

  localparam int QUEUE_DEPTH  = 16;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int NUM_PHASES   = 8;
  localparam int PHASE_WORDS  = 180;
  localparam int SETTLE_WAIT  = 24;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  in_word_t           in_word;
  logic               out_valid;
  out_word_t          out_word;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  entry_t      ready_list[$];
  logic [1:0]  model_key_mode;
  logic [15:0] model_default_prio;
  out_word_t   pending_words[$];

  int  error_count;
  int  cycle_count;
  int  num_inserts;
  int  num_pops;
  int  num_full;
  int  num_empty;
  int  num_cfg_writes;
  int  num_checked;
  bit  gaps_on;

  priority_ready_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               pending_words.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic report_mismatch(string what, longint got, longint want);
    error_count++;
    if (error_count <= 40)
      $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h", cycle_count, what,
               got, want);
  endtask

  // sorted insert after equal keys, head pop
  function automatic out_word_t predict_queue(in_word_t w);
    out_word_t   r;
    logic [15:0] key;
    entry_t      e;
    int          pos;
    r = '0;
    if (w.req_type == REQ_INSERT) begin
      if (ready_list.size() >= QUEUE_DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        case (model_key_mode)
          MODE_SJF:  key = w.burst_estimate;
          MODE_PRIO: key = w.job_priority;
          default:   key = model_default_prio;
        endcase
        pos = 0;
        while (pos < ready_list.size() && ready_list[pos].key <= key) pos++;
        e.key = key;
        e.id  = w.task_id;
        ready_list.insert(pos, e);
        r.status = STATUS_DONE;
      end
    end else if (ready_list.size() == 0) begin
      r.status = STATUS_EMPTY;
    end else begin
      e = ready_list.pop_front();
      r.status     = STATUS_DONE;
      r.popped_id  = e.id;
      r.popped_key = e.key;
    end
    r.occupancy = 5'(ready_list.size());
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word, status", out_word.status, 0);
      end else begin
        want = pending_words.pop_front();
        num_checked++;
        if (out_word.status !== want.status)
          report_mismatch("status", out_word.status, want.status);
        if (out_word.popped_id !== want.popped_id)
          report_mismatch("popped_id", out_word.popped_id, want.popped_id);
        if (out_word.popped_key !== want.popped_key)
          report_mismatch("popped_key", out_word.popped_key, want.popped_key);
        if (out_word.occupancy !== want.occupancy)
          report_mismatch("occupancy", out_word.occupancy, want.occupancy);
      end
    end
  end

  task automatic send_word(in_word_t w);
    out_word_t r;
    int        gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      repeat (gap) begin
        @(negedge clk);
        start <= 1'b0;
      end
    end
    @(negedge clk);
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    r = predict_queue(w);
    pending_words.push_back(r);
    if (w.req_type == REQ_POP) num_pops++;
    else num_inserts++;
    if (r.status == STATUS_FULL) num_full++;
    if (r.status == STATUS_EMPTY) num_empty++;
  endtask

  task automatic send_insert(logic [7:0] id, logic [15:0] burst, logic [15:0] prio);
    in_word_t w;
    w.req_type       = REQ_INSERT;
    w.task_id        = id;
    w.burst_estimate = burst;
    w.job_priority   = prio;
    send_word(w);
  endtask

  task automatic send_pop();
    in_word_t w;
    w = in_word_t'({$urandom, $urandom});
    w.req_type = REQ_POP;
    send_word(w);
  endtask

  task automatic drain_queue();
    @(negedge clk);
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic cfg_read_check(logic reg_sel, logic [31:0] want);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {reg_sel, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want) report_mismatch("register read", prdata, want);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic cfg_write(logic reg_sel, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (reg_sel == REG_KEY_MODE) model_key_mode = value[1:0];
    else model_default_prio = value[15:0];
    num_cfg_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_read_check(reg_sel, reg_sel == REG_KEY_MODE ? {30'd0, value[1:0]}
                                                    : {16'd0, value[15:0]});
  endtask

  task automatic set_mode(logic [1:0] mode, logic [15:0] dflt);
    drain_queue();
    cfg_write(REG_KEY_MODE, {30'd0, mode});
    cfg_write(REG_DEFAULT_PRIO, {16'd0, dflt});
  endtask

  function automatic logic [15:0] random_key();
    case ($urandom_range(0, 9))
      0:         return 16'h0000;
      1:         return 16'hFFFF;
      2, 3, 4, 5: return 16'($urandom_range(0, 7));
      default:   return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic test_reset_and_fcfs();
    cfg_read_check(REG_KEY_MODE, 32'd0);
    cfg_read_check(REG_DEFAULT_PRIO, 32'd0);
    send_pop();
    send_insert(8'hFF, 16'hFFFF, 16'hFFFF);
    send_insert(8'h00, 16'h0000, 16'h0000);
    send_insert(8'hA5, 16'h1234, 16'h0001);
    send_pop();
    send_pop();
    send_pop();
    send_pop();
  endtask

  // equal keys, both key extremes, then overflow
  task automatic test_fill_sjf();
    logic [15:0] bursts[16];
    bursts = '{16'hFFFF, 16'h0000, 16'h0005, 16'h0005, 16'hFFFF, 16'h0001, 16'h0000,
               16'h8000, 16'h7FFF, 16'h0005, 16'h0002, 16'hFFFE, 16'h0000, 16'h0003,
               16'h8000, 16'h0004};
    set_mode(MODE_SJF, 16'h0000);
    for (int i = 0; i < QUEUE_DEPTH; i++)
      send_insert(8'(8'h10 + i), bursts[i], ~bursts[i]);
    send_insert(8'hEE, 16'h0000, 16'h0000);
    repeat (4) send_pop();
  endtask

  task automatic test_prio_and_unused_mode();
    set_mode(MODE_PRIO, 16'h0000);
    send_insert(8'h01, 16'h0000, 16'hFFFF);
    send_insert(8'h02, 16'hFFFF, 16'h0000);
    send_pop();
    set_mode(MODE_UNUSED, 16'hFFFF);
    send_insert(8'h03, 16'h0000, 16'h0000);
    send_pop();
  endtask

  task automatic test_random_phases();
    logic [1:0]  modes[NUM_PHASES];
    logic [15:0] dflt;
    int          insert_pct;
    modes = '{MODE_FCFS, MODE_SJF, MODE_PRIO, MODE_UNUSED, MODE_SJF, MODE_PRIO,
              MODE_FCFS, MODE_PRIO};
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 3)
        0:       dflt = 16'hFFFF;
        1:       dflt = 16'h0000;
        default: dflt = 16'($urandom_range(0, 65535));
      endcase
      set_mode(modes[p], dflt);
      gaps_on = (p < NUM_PHASES - 1) && ($urandom_range(0, 4) != 0);
      insert_pct = 50;
      for (int k = 0; k < PHASE_WORDS; k++) begin
        // shifting bias walks the queue between empty and full
        if (k % 30 == 0) insert_pct = $urandom_range(1, 4) * 20;
        if ($urandom_range(1, 100) <= insert_pct)
          send_insert(8'($urandom_range(0, 255)), random_key(), random_key());
        else
          send_pop();
      end
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_word     = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    cycle_count = 0;
    error_count = 0;
    gaps_on     = 1'b1;
    model_key_mode     = MODE_FCFS;
    model_default_prio = 16'h0000;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_and_fcfs();
    test_fill_sjf();
    test_prio_and_unused_mode();
    test_random_phases();

    drain_queue();
    if (pending_words.size() != 0)
      report_mismatch("words never returned", pending_words.size(), 0);
    $display("covered %0d inserts, %0d pops, %0d full refusals, %0d empty refusals",
             num_inserts, num_pops, num_full, num_empty);
    $display("%0d words checked, %0d register writes, %0d mismatches", num_checked,
             num_cfg_writes, error_count);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/prq_pkg.sv
src/prq_cfg.sv
src/prq_ram.sv
src/prq_seq.sv
src/priority_ready_queue.sv
src/prq_checker.sv
verif/tb_top.sv
